// ===== rtl/tnrf_pkg.sv =====
// shared byte codes and result type for the telnet receive filter
`timescale 1ns / 1ps
package tnrf_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] TN_IAC  = 8'hFF;
	localparam logic [ByteW-1:0] TN_DONT = 8'hFE;
	localparam logic [ByteW-1:0] TN_DO   = 8'hFD;
	localparam logic [ByteW-1:0] TN_WONT = 8'hFC;
	localparam logic [ByteW-1:0] TN_WILL = 8'hFB;
	localparam logic [ByteW-1:0] TN_SB   = 8'hFA;
	localparam logic [ByteW-1:0] TN_EC   = 8'hF7;
	localparam logic [ByteW-1:0] TN_SE   = 8'hF0;

	localparam logic [ByteW-1:0] BACKSPACE_BYTE = 8'h08;
	localparam logic [ByteW-1:0] NUL_BYTE       = 8'h00;

	typedef struct packed {
		logic             emit;
		logic [ByteW-1:0] data;
	} tnrf_result_t;

endpackage

// ===== rtl/telnet_receive_filter.sv =====
// top level of the telnet receive filter
`timescale 1ns / 1ps
// Strips telnet commands from a received byte stream: one byte is taken per
// clock on in_valid/in_ready and at most one data byte comes out on
// out_valid/out_ready in the next cycle, from a single output register. NUL in
// data is dropped, IAC IAC gives 0xFF, IAC EC gives a backspace, IAC
// WILL/WONT/DO/DONT drops the option byte too, and IAC SB drops everything
// through IAC SE. Sustained rate is one byte per cycle; in_ready falls only
// while the output register is full and out_ready is low.
module telnet_receive_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tnrf_pkg::ByteW-1:0]      in_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tnrf_pkg::ByteW-1:0]      out_byte
);

	tnrf_pkg::tnrf_result_t result;
	logic                   take;

	assign take = in_valid && in_ready;

	tnrf_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (in_byte),
		.result  (result)
	);

	tnrf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.result    (result),
		.can_take  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte)
	);

endmodule

// ===== rtl/tnrf_parse.sv =====
// telnet command parse state and per-byte decode
`timescale 1ns / 1ps
module tnrf_parse (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [tnrf_pkg::ByteW-1:0]      in_byte,
	output tnrf_pkg::tnrf_result_t          result
);

	typedef enum logic [2:0] {
		PH_DATA   = 3'd0,
		PH_IAC    = 3'd1,
		PH_OPT    = 3'd2,
		PH_SB     = 3'd3,
		PH_SB_IAC = 3'd4
	} phase_t;

	phase_t phase_q;
	phase_t phase_nxt;

	always_comb begin
		phase_nxt   = PH_DATA;
		result.emit = 1'b0;
		result.data = in_byte;
		case (phase_q)
			PH_IAC: begin
				if (in_byte == tnrf_pkg::TN_IAC) begin
					result.emit = 1'b1;
					result.data = tnrf_pkg::TN_IAC;
				end else if (in_byte == tnrf_pkg::TN_EC) begin
					result.emit = 1'b1;
					result.data = tnrf_pkg::BACKSPACE_BYTE;
				end else if (in_byte inside {tnrf_pkg::TN_WILL, tnrf_pkg::TN_WONT,
						tnrf_pkg::TN_DO, tnrf_pkg::TN_DONT}) begin
					phase_nxt = PH_OPT;
				end else if (in_byte == tnrf_pkg::TN_SB) begin
					phase_nxt = PH_SB;
				end
			end
			PH_OPT: begin
				phase_nxt = PH_DATA;
			end
			PH_SB: begin
				phase_nxt = (in_byte == tnrf_pkg::TN_IAC) ? PH_SB_IAC : PH_SB;
			end
			PH_SB_IAC: begin
				// a doubled iac keeps waiting for se
				if (in_byte == tnrf_pkg::TN_SE) begin
					phase_nxt = PH_DATA;
				end else if (in_byte == tnrf_pkg::TN_IAC) begin
					phase_nxt = PH_SB_IAC;
				end else begin
					phase_nxt = PH_SB;
				end
			end
			default: begin
				// plain data, also any unreachable code
				if (in_byte == tnrf_pkg::TN_IAC) begin
					phase_nxt = PH_IAC;
				end else if (in_byte != tnrf_pkg::NUL_BYTE) begin
					result.emit = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
		end else if (take) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

// ===== rtl/tnrf_out_stage.sv =====
// output register holding one filtered byte until it is taken
`timescale 1ns / 1ps
module tnrf_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  tnrf_pkg::tnrf_result_t          result,
	output logic                            can_take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tnrf_pkg::ByteW-1:0]      out_byte
);

	logic                       valid_q;
	logic [tnrf_pkg::ByteW-1:0] byte_q;

	// room when empty or the held byte leaves this cycle
	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= result.emit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && result.emit) begin
			byte_q <= result.data;
		end
	end

endmodule

// ===== rtl/tnrf_checker.sv =====
// port-level checks for the telnet receive filter, bound to the top level
`timescale 1ns / 1ps
module tnrf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [tnrf_pkg::ByteW-1:0]      in_byte,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tnrf_pkg::ByteW-1:0]      out_byte
);

	// a waiting request keeps its byte until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte))
		else $error("input byte changed while stalled");

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output byte changed while stalled");

	// an empty output register always takes a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// no result appears without a request accepted
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("result without request");

	// nul is never delivered
	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_byte != tnrf_pkg::NUL_BYTE)
		else $error("nul byte delivered");

endmodule

bind telnet_receive_filter tnrf_checker u_tnrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_byte   (in_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte)
);
